### rtl/sta_pkg.sv
// sta_pkg: shared types and constants for the station traffic accumulator
// used by sta_ctrl, sta_dpath and station_traffic_accumulator_top
`timescale 1ns / 1ps

package sta_pkg;

  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned BYTES_W = 16;

  localparam logic [TOTAL_W-1:0] SUM_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPD,
    ST_FRD,
    ST_FEMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic look;
    logic update;
    logic frd;
    logic emit;
    logic clear;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic flush_last;
  } dp_sts_t;

endpackage

### rtl/sta_ctrl.sv
// sta_ctrl: sequencer for record lookup/update and flush readout
// depends on sta_pkg
`timescale 1ns / 1ps

module sta_ctrl
  import sta_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_flush_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE, ST_UPD: begin
        if (in_valid_i) begin
          state_d = in_flush_i ? ST_FRD : ST_LOOK;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_LOOK: begin
        state_d = ST_UPD;
      end
      ST_FRD: begin
        state_d = ST_FEMIT;
      end
      ST_FEMIT: begin
        if (sts_i.out_free) begin
          state_d = sts_i.flush_last ? ST_IDLE : ST_FRD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_LOOK: begin
        cmd_o.look = 1'b1;
      end
      ST_UPD: begin
        in_ready_o   = 1'b1;
        cmd_o.load   = in_valid_i;
        cmd_o.update = 1'b1;
      end
      ST_FRD: begin
        cmd_o.frd = 1'b1;
      end
      ST_FEMIT: begin
        cmd_o.emit  = sts_i.out_free;
        cmd_o.clear = sts_i.out_free & sts_i.flush_last;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

### rtl/sta_dpath.sv
// sta_dpath: key compare rows, totals/key memories, counters and output register
// depends on sta_pkg
`timescale 1ns / 1ps

module sta_dpath
  import sta_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic [ADDR_W-1:0]  tx_addr_i,
  input  logic [ADDR_W-1:0]  rx_addr_i,
  input  logic [BYTES_W-1:0] bytes_i,
  input  dp_cmd_t            cmd_i,
  output dp_sts_t            sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ADDR_W-1:0]  out_addr_o,
  output logic [TOTAL_W-1:0] out_total_o,
  output logic               out_entry_valid_o,
  output logic               out_sat_o,
  output logic               out_ovf_o,
  output logic               out_last_o
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  logic                use_rx_q;
  logic [ADDR_W-1:0]   key_q;
  logic [BYTES_W-1:0]  bytes_q;

  logic [ADDR_W-1:0]   cam_q [TABLE_DEPTH];
  logic [ADDR_W-1:0]   key_mem [TABLE_DEPTH];
  logic [TOTAL_W:0]    tot_mem [TABLE_DEPTH];

  logic [CNT_W-1:0]    used_q;
  logic                dropped_q;
  logic [IDX_W-1:0]    fidx_q;

  logic [TABLE_DEPTH-1:0] hit_vec;
  logic [IDX_W-1:0]    enc_idx;
  logic                hit_q;
  logic [IDX_W-1:0]    hit_idx_q;

  logic [IDX_W-1:0]    rd_addr;
  logic [ADDR_W-1:0]   rd_key_q;
  logic [TOTAL_W-1:0]  rd_total_q;
  logic                rd_sat_q;

  logic [TOTAL_W:0]    sum;
  logic                sum_sat;
  logic                table_full;
  logic                table_empty;
  logic [IDX_W-1:0]    ins_idx;
  logic [CNT_W-1:0]    fidx_next;

  logic                out_valid_q;
  logic [ADDR_W-1:0]   out_addr_q;
  logic [TOTAL_W-1:0]  out_total_q;
  logic                out_entry_valid_q;
  logic                out_sat_q;
  logic                out_ovf_q;
  logic                out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_rx_q <= 1'b0;
    end else if (cfg_we_i) begin
      use_rx_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q   <= use_rx_q ? rx_addr_i : tx_addr_i;
      bytes_q <= bytes_i;
    end
  end

  // parallel key compare over rows in use
  always_comb begin
    hit_vec = '0;
    enc_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_vec[i] = (CNT_W'(i) < used_q) && (cam_q[i] == key_q);
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (hit_vec[i]) begin
        enc_idx = enc_idx | IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.look) begin
      hit_q     <= |hit_vec;
      hit_idx_q <= enc_idx;
    end
  end

  assign rd_addr = cmd_i.look ? enc_idx : fidx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.look || cmd_i.frd) begin
      rd_key_q                <= key_mem[rd_addr];
      {rd_sat_q, rd_total_q}  <= tot_mem[rd_addr];
    end
  end

  assign table_full  = (used_q == CNT_W'(TABLE_DEPTH));
  assign table_empty = (used_q == '0);
  assign ins_idx     = used_q[IDX_W-1:0];
  assign sum         = {1'b0, rd_total_q} + (TOTAL_W + 1)'(bytes_q);
  assign sum_sat     = (sum >= {1'b0, SUM_MAX});

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      if (hit_q) begin
        tot_mem[hit_idx_q] <= sum_sat ? {1'b1, SUM_MAX} : {rd_sat_q, sum[TOTAL_W-1:0]};
      end else if (!table_full) begin
        tot_mem[ins_idx] <= {1'b0, TOTAL_W'(bytes_q)};
        key_mem[ins_idx] <= key_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update && !hit_q && !table_full) begin
      cam_q[ins_idx] <= key_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      dropped_q <= 1'b0;
    end else if (cmd_i.clear) begin
      used_q    <= '0;
      dropped_q <= 1'b0;
    end else if (cmd_i.update && !hit_q) begin
      if (table_full) begin
        dropped_q <= 1'b1;
      end else begin
        used_q <= used_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fidx_q <= '0;
    end else if (cmd_i.load) begin
      fidx_q <= '0;
    end else if (cmd_i.emit) begin
      fidx_q <= fidx_q + 1'b1;
    end
  end

  assign fidx_next = CNT_W'(fidx_q) + 1'b1;

  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.flush_last = table_empty || (fidx_next == used_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_addr_q        <= table_empty ? '0 : rd_key_q;
      out_total_q       <= table_empty ? '0 : rd_total_q;
      out_entry_valid_q <= !table_empty;
      out_sat_q         <= !table_empty && rd_sat_q;
      out_ovf_q         <= dropped_q;
      out_last_q        <= sts_o.flush_last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_addr_o        = out_addr_q;
  assign out_total_o       = out_total_q;
  assign out_entry_valid_o = out_entry_valid_q;
  assign out_sat_o         = out_sat_q;
  assign out_ovf_o         = out_ovf_q;
  assign out_last_o        = out_last_q;

`ifndef SYNTH
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_hit_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.look |-> $onehot0(hit_vec))
    else $error("key matched more than one row");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (used_q == '0) && !dropped_q)
    else $error("flush did not clear table");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("output word overwritten while stalled");
`endif

endmodule

### rtl/station_traffic_accumulator_top.sv
// station_traffic_accumulator_top: per-address byte counter table, top level
// depends on sta_pkg, sta_ctrl and sta_dpath
`timescale 1ns / 1ps

// a record word (tuser 0) can be taken while the previous record is written back: the
// LOOK state compares the key against all rows in use in parallel and reads the totals
// memory, then the UPD state adds the byte count and writes it back, or puts a new key in
// a free row, while the next word is taken. a flush word (tuser 1) reads the totals and
// key memories one entry at a time, FRD then FEMIT for each, and emits entries in
// first-seen order; an output stall holds FEMIT, and the next word is taken in the idle
// state after the last entry is emitted. an empty table gives one word with entry_valid
// low. results wait in an output register. no clearing pass is needed after reset.
module station_traffic_accumulator_top
  import sta_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,    // use_receiver
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,   // transmitter_addr, receiver_addr, packet_bytes
  input  logic [0:0]   s_axis_tuser,   // cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [79:0]  m_axis_tdata,   // station_addr, total_bytes
  output logic [2:0]   m_axis_tuser,   // entry_valid, sum_saturated, table_overflowed
  output logic         m_axis_tlast
);

  dp_cmd_t             cmd;
  dp_sts_t             sts;
  logic [ADDR_W-1:0]   out_addr;
  logic [TOTAL_W-1:0]  out_total;

  sta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_flush_i (s_axis_tuser[0]),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sta_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .tx_addr_i         (s_axis_tdata[47:0]),
    .rx_addr_i         (s_axis_tdata[95:48]),
    .bytes_i           (s_axis_tdata[111:96]),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .out_addr_o        (out_addr),
    .out_total_o       (out_total),
    .out_entry_valid_o (m_axis_tuser[0]),
    .out_sat_o         (m_axis_tuser[1]),
    .out_ovf_o         (m_axis_tuser[2]),
    .out_last_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {out_total, out_addr};

endmodule

### test/station_traffic_accumulator_top_tb.sv
// station_traffic_accumulator_top_tb: stream testbench for the per-station byte counter table
// drives record and flush words, predicts reports from its own table copy or fixed rows and checks them
// depends on sta_pkg and station_traffic_accumulator_top
`timescale 1ns / 1ps

module station_traffic_accumulator_top_tb;
  import sta_pkg::*;

  localparam int DEPTH         = 64;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 600;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  localparam logic MODE_TX = 1'b0;
  localparam logic MODE_RX = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [ADDR_W-1:0]  tx;
    logic [ADDR_W-1:0]  rx;
    logic [BYTES_W-1:0] bytes;
  } word_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [TOTAL_W-1:0] total;
    logic               valid;
    logic               sat;
    logic               ovf;
    logic               last;
  } report_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    word_t     w;
    logic      typed;
    report_t   want;
    logic      mode;
  } row_t;

  logic         clk       = 1'b0;
  logic         rst_n     = 1'b0;
  logic         cfg_we    = 1'b0;
  logic         cfg_wdata = 1'b0;
  logic         s_valid   = 1'b0;
  logic         s_ready;
  logic [111:0] s_tdata   = '0;
  logic [0:0]   s_tuser   = '0;
  logic         m_valid;
  logic         m_ready   = 1'b0;
  logic [79:0]  m_tdata;
  logic [2:0]   m_tuser;
  logic         m_tlast;

  // table copy
  logic [ADDR_W-1:0]  tbl_key   [DEPTH];
  logic [TOTAL_W-1:0] tbl_total [DEPTH];
  logic               tbl_sat   [DEPTH];
  int                 tbl_used    = 0;
  logic               tbl_dropped = 1'b0;
  logic               key_on_rx   = MODE_TX;

  report_t due_reports [$];
  row_t    dir_rows [$];

  int tx_idle_pct  = 33;
  int rx_idle_pct  = 82;
  int hold_left    = 0;
  int stall_cycles = 0;
  int errs         = 0;
  int words_sent   = 0;
  int reports_seen = 0;
  int flushes      = 0;
  int ovf_flushes  = 0;
  int sat_entries  = 0;
  int cfg_writes   = 0;
  report_t mon_exp;
  report_t mon_act;

  station_traffic_accumulator_top #(
    .TABLE_DEPTH(DEPTH)
  ) u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_tdata),
    .m_axis_tuser (m_tuser),
    .m_axis_tlast (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic tally_word(input word_t w, input bit keep);
    logic [ADDR_W-1:0]  key;
    logic [TOTAL_W:0]   sum;
    report_t            r;
    int                 hit;
    if (w.cmd == CMD_RECORD) begin
      key = key_on_rx ? w.rx : w.tx;
      hit = -1;
      for (int i = 0; i < tbl_used; i++) begin
        if (hit < 0 && tbl_key[i] == key) hit = i;
      end
      if (hit >= 0) begin
        sum = {1'b0, tbl_total[hit]} + (TOTAL_W + 1)'(w.bytes);
        if (sum >= {1'b0, SUM_MAX}) begin
          sum = {1'b0, SUM_MAX};
          tbl_sat[hit] = 1'b1;
        end
        tbl_total[hit] = sum[TOTAL_W-1:0];
      end else if (tbl_used < DEPTH) begin
        tbl_key[tbl_used]   = key;
        tbl_total[tbl_used] = TOTAL_W'(w.bytes);
        tbl_sat[tbl_used]   = 1'b0;
        tbl_used++;
      end else begin
        tbl_dropped = 1'b1;
      end
    end else begin
      flushes++;
      if (tbl_dropped) ovf_flushes++;
      if (tbl_used == 0) begin
        r = '0;
        r.ovf  = tbl_dropped;
        r.last = 1'b1;
        if (keep) due_reports.push_back(r);
      end else begin
        for (int i = 0; i < tbl_used; i++) begin
          r.addr  = tbl_key[i];
          r.total = tbl_total[i];
          r.valid = 1'b1;
          r.sat   = tbl_sat[i];
          r.ovf   = tbl_dropped;
          r.last  = (i == tbl_used - 1);
          if (tbl_sat[i]) sat_entries++;
          if (keep) due_reports.push_back(r);
        end
      end
      tbl_used    = 0;
      tbl_dropped = 1'b0;
    end
  endtask

  // entered and left at a falling edge
  task automatic send_word(input word_t w, input bit keep);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk);
    end
    s_valid <= 1'b1;
    s_tdata <= {w.bytes, w.rx, w.tx};
    s_tuser <= w.cmd;
    do @(posedge clk); while (!s_ready);
    @(negedge clk);
    words_sent++;
    tally_word(w, keep);
  endtask

  task automatic settle();
    s_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_mode(input logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    key_on_rx  = v;
    cfg_writes++;
  endtask

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[ADDR_W-1:0];
  endfunction

  function automatic logic [BYTES_W-1:0] rand_bytes();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return BYTES_W'($urandom_range(16'hFFFF));
  endfunction

  function automatic word_t mk_word(input logic cmd, input logic [ADDR_W-1:0] tx,
                                    input logic [ADDR_W-1:0] rx,
                                    input logic [BYTES_W-1:0] bytes);
    word_t w;
    w.cmd = cmd;
    w.tx = tx;
    w.rx = rx;
    w.bytes = bytes;
    return w;
  endfunction

  function automatic word_t keyed_word(input logic [ADDR_W-1:0] key,
                                       input logic [BYTES_W-1:0] bytes);
    if (key_on_rx) return mk_word(CMD_RECORD, rand_addr(), key, bytes);
    return mk_word(CMD_RECORD, key, rand_addr(), bytes);
  endfunction

  function automatic row_t row_word(input logic cmd, input logic [ADDR_W-1:0] tx,
                                    input logic [ADDR_W-1:0] rx,
                                    input logic [BYTES_W-1:0] bytes);
    row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.w = mk_word(cmd, tx, rx, bytes);
    return r;
  endfunction

  function automatic row_t row_check(input logic [ADDR_W-1:0] tx, input logic [ADDR_W-1:0] rx,
                                     input logic [BYTES_W-1:0] bytes,
                                     input logic [ADDR_W-1:0] addr,
                                     input logic [TOTAL_W-1:0] total, input logic valid);
    row_t r;
    r = row_word(CMD_FLUSH, tx, rx, bytes);
    r.typed      = 1'b1;
    r.want.addr  = addr;
    r.want.total = total;
    r.want.valid = valid;
    r.want.sat   = 1'b0;
    r.want.ovf   = 1'b0;
    r.want.last  = 1'b1;
    return r;
  endfunction

  function automatic row_t row_cfg(input logic mode);
    row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.mode = mode;
    return r;
  endfunction

  task automatic flush_word();
    send_word(mk_word(CMD_FLUSH, rand_addr(), rand_addr(), rand_bytes()), 1'b1);
  endtask

  task automatic run_session(input int pool_n, input int rec_n);
    logic [ADDR_W-1:0] pool [80];
    int idx;
    for (int i = 0; i < pool_n; i++) begin
      pool[i] = ($urandom_range(7) == 0) ? ADDR_W'($urandom_range(15)) : rand_addr();
    end
    for (int i = 0; i < rec_n; i++) begin
      idx = (i < pool_n) ? i : $urandom_range(pool_n - 1);
      if ($urandom_range(19) == 0)
        send_word(mk_word(CMD_RECORD, rand_addr(), rand_addr(), rand_bytes()), 1'b1);
      else
        send_word(keyed_word(pool[idx], rand_bytes()), 1'b1);
    end
    if ($urandom_range(9) != 0) flush_word();
  endtask

  task automatic run_phase(input int target);
    int start;
    int pool_n;
    int pick;
    start = words_sent;
    while (words_sent - start < target) begin
      pick = $urandom_range(9);
      if (pick < 7) pool_n = $urandom_range(6, 1);
      else if (pick < 9) pool_n = $urandom_range(20, 7);
      else pool_n = $urandom_range(70, 60);
      run_session(pool_n, pool_n * $urandom_range(3, 1));
      if ($urandom_range(9) == 0) flush_word();
      if ($urandom_range(3) == 0) begin
        settle();
        write_mode(1'($urandom_range(1)));
      end
    end
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_ready <= 1'b0;
      hold_left--;
    end else begin
      m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) begin
      mon_act.addr  = m_tdata[47:0];
      mon_act.total = m_tdata[79:48];
      mon_act.valid = m_tuser[0];
      mon_act.sat   = m_tuser[1];
      mon_act.ovf   = m_tuser[2];
      mon_act.last  = m_tlast;
      if (due_reports.size() == 0) begin
        errs++;
        if (errs <= 10) $display("unexpected word: addr %h total %h v%b s%b o%b l%b",
                                 mon_act.addr, mon_act.total, mon_act.valid, mon_act.sat,
                                 mon_act.ovf, mon_act.last);
      end else begin
        mon_exp = due_reports.pop_front();
        reports_seen++;
        if (mon_act !== mon_exp) begin
          errs++;
          if (errs <= 10) begin
            $display("mismatch: expected addr %h total %h v%b s%b o%b l%b",
                     mon_exp.addr, mon_exp.total, mon_exp.valid, mon_exp.sat,
                     mon_exp.ovf, mon_exp.last);
            $display("          got      addr %h total %h v%b s%b o%b l%b",
                     mon_act.addr, mon_act.total, mon_act.valid, mon_act.sat,
                     mon_act.ovf, mon_act.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("station_traffic_accumulator_top_tb: errors");
      $finish;
    end
  end

  initial begin
    dir_rows.push_back(row_check('0, '0, '0, '0, '0, 1'b0));
    dir_rows.push_back(row_word(CMD_RECORD, '1, '0, '1));
    dir_rows.push_back(row_check('0, '1, '0, '1, 32'h0000_FFFF, 1'b1));
    dir_rows.push_back(row_word(CMD_RECORD, '0, '1, '0));
    dir_rows.push_back(row_check('0, '0, '0, '0, '0, 1'b1));
    dir_rows.push_back(row_word(CMD_RECORD, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 16'hAAAA));
    dir_rows.push_back(row_word(CMD_RECORD, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 16'h5555));
    dir_rows.push_back(row_word(CMD_RECORD, 48'hAAAA_AAAA_AAAA, 48'h0123_4567_89AB, '1));
    dir_rows.push_back(row_word(CMD_RECORD, '0, 48'hAAAA_AAAA_AAAA, 16'h0001));
    dir_rows.push_back(row_word(CMD_RECORD, 48'h5555_5555_5555, '0, '0));
    dir_rows.push_back(row_word(CMD_FLUSH, '0, '0, '0));
    dir_rows.push_back(row_check('1, '1, '1, '0, '0, 1'b0));
    dir_rows.push_back(row_cfg(MODE_RX));
    dir_rows.push_back(row_word(CMD_RECORD, 48'h1234_5678_9ABC, 48'h5555_5555_5555, 16'h5555));
    dir_rows.push_back(row_word(CMD_RECORD, 48'hFEDC_BA98_7654, 48'h5555_5555_5555, 16'hAAAA));
    dir_rows.push_back(row_word(CMD_RECORD, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 16'h0001));
    dir_rows.push_back(row_word(CMD_FLUSH, '1, '0, '1));
    dir_rows.push_back(row_cfg(MODE_TX));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        settle();
        write_mode(dir_rows[i].mode);
      end else begin
        send_word(dir_rows[i].w, !dir_rows[i].typed);
        if (dir_rows[i].typed) due_reports.push_back(dir_rows[i].want);
      end
    end

    // receiver stalls while a wide flush and more records pile up behind it
    hold_left = HOLD_CYCLES;
    run_session(16, 32);
    flush_word();
    run_session(3, 6);
    run_phase(70);
    settle();
    write_mode(MODE_RX);

    tx_idle_pct = 82;
    rx_idle_pct = 33;
    run_session(DEPTH, DEPTH + 10);
    run_phase(70);
    settle();
    write_mode(1'($urandom_range(1)));

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_session(70, 100);
    run_phase(70);
    settle();
    repeat (20) @(posedge clk);

    $display("sent %0d words, checked %0d reports over %0d flushes and %0d mode writes",
             words_sent, reports_seen, flushes, cfg_writes);
    $display("flushes after a dropped station: %0d, saturated entries reported: %0d",
             ovf_flushes, sat_entries);
    if (errs == 0 && due_reports.size() == 0) begin
      $display("station_traffic_accumulator_top_tb: clean");
    end else begin
      $display("station_traffic_accumulator_top_tb: errors");
    end
    $finish;
  end

endmodule

### files.f
rtl/sta_pkg.sv
rtl/sta_ctrl.sv
rtl/sta_dpath.sv
rtl/station_traffic_accumulator_top.sv
test/station_traffic_accumulator_top_tb.sv
